[rtl/core/ilt_pkg.sv]
// Package for the INI line tokenizer: byte classes, event codes, parser states
// and the classification and transition functions shared by the front and back.
// No dependencies.
`timescale 1ns / 1ps

package ilt_pkg;

  typedef enum logic [2:0] {
    CLS_BLANK = 3'd0,
    CLS_STR   = 3'd1,
    CLS_OPEN  = 3'd2,
    CLS_CLOSE = 3'd3,
    CLS_EQ    = 3'd4,
    CLS_NL    = 3'd5,
    CLS_BAD   = 3'd6
  } cls_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SECT_CH  = 3'd1,
    EV_KEY_CH   = 3'd2,
    EV_VAL_CH   = 3'd3,
    EV_SECT_END = 3'd4,
    EV_PAIR_END = 3'd5,
    EV_ERROR    = 3'd6,
    EV_HALTED   = 3'd7
  } ev_e;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_SECT_OPEN = 11'b000_0000_0010,
    S_SECT_CH   = 11'b000_0000_0100,
    S_SECT_BLNK = 11'b000_0000_1000,
    S_LINE_END  = 11'b000_0001_0000,
    S_COMMIT    = 11'b000_0010_0000,
    S_KEY_CH    = 11'b000_0100_0000,
    S_KEY_BLNK  = 11'b000_1000_0000,
    S_EQ_BLNK   = 11'b001_0000_0000,
    S_VAL_CH    = 11'b010_0000_0000,
    S_VAL_BLNK  = 11'b100_0000_0000
  } dfa_state_e;

  localparam logic [7:0] CharNl   = 8'h0A;
  localparam logic [7:0] CharHash = 8'h23;

  // Classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] ch;
    cls_e       cls;
    logic       is_nl;
    logic       is_hash;
  } tok_t;

  // One result transaction.
  typedef struct packed {
    ev_e         ev;
    logic [7:0]  ch;
    logic [15:0] line;
    logic [15:0] col;
  } res_t;

  typedef struct packed {
    logic       reject;
    dfa_state_e nxt;
  } dfa_step_t;

  function automatic cls_e classify(logic [7:0] c);
    cls_e cls;
    if (c inside {8'h20, 8'h09}) cls = CLS_BLANK;
    else if (c == CharNl) cls = CLS_NL;
    else if (c == 8'h3D) cls = CLS_EQ;
    else if (c == 8'h5B) cls = CLS_OPEN;
    else if (c == 8'h5D) cls = CLS_CLOSE;
    else if (c inside {[8'h21:8'h7E], [8'h80:8'hFF]}) cls = CLS_STR;
    else cls = CLS_BAD;
    return cls;
  endfunction

  // One step of the line grammar; any pair not listed is a syntax error.
  function automatic dfa_step_t dfa_next(dfa_state_e cur, cls_e cls);
    dfa_step_t s;
    s.reject = 1'b1;
    s.nxt    = cur;
    case (cur)
      S_IDLE: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_IDLE; end
          CLS_OPEN:  begin s.reject = 1'b0; s.nxt = S_SECT_OPEN; end
          CLS_NL:    begin s.reject = 1'b0; s.nxt = S_IDLE; end
          default:   s.reject = 1'b1;
        endcase
      end
      S_SECT_OPEN: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_SECT_OPEN; end
          CLS_STR:   begin s.reject = 1'b0; s.nxt = S_SECT_CH; end
          default:   s.reject = 1'b1;
        endcase
      end
      S_SECT_CH: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_SECT_BLNK; end
          CLS_STR:   begin s.reject = 1'b0; s.nxt = S_SECT_CH; end
          CLS_CLOSE: begin s.reject = 1'b0; s.nxt = S_LINE_END; end
          default:   s.reject = 1'b1;
        endcase
      end
      S_SECT_BLNK: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_SECT_BLNK; end
          CLS_CLOSE: begin s.reject = 1'b0; s.nxt = S_LINE_END; end
          default:   s.reject = 1'b1;
        endcase
      end
      S_LINE_END: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_LINE_END; end
          CLS_NL:    begin s.reject = 1'b0; s.nxt = S_COMMIT; end
          default:   s.reject = 1'b1;
        endcase
      end
      S_COMMIT: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_COMMIT; end
          CLS_STR:   begin s.reject = 1'b0; s.nxt = S_KEY_CH; end
          CLS_OPEN:  begin s.reject = 1'b0; s.nxt = S_SECT_OPEN; end
          CLS_NL:    begin s.reject = 1'b0; s.nxt = S_COMMIT; end
          default:   s.reject = 1'b1;
        endcase
      end
      S_KEY_CH: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_KEY_BLNK; end
          CLS_STR:   begin s.reject = 1'b0; s.nxt = S_KEY_CH; end
          CLS_EQ:    begin s.reject = 1'b0; s.nxt = S_EQ_BLNK; end
          default:   s.reject = 1'b1;
        endcase
      end
      S_KEY_BLNK: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_KEY_BLNK; end
          CLS_EQ:    begin s.reject = 1'b0; s.nxt = S_EQ_BLNK; end
          default:   s.reject = 1'b1;
        endcase
      end
      S_EQ_BLNK: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_EQ_BLNK; end
          CLS_STR:   begin s.reject = 1'b0; s.nxt = S_VAL_CH; end
          default:   s.reject = 1'b1;
        endcase
      end
      S_VAL_CH: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_VAL_BLNK; end
          CLS_STR:   begin s.reject = 1'b0; s.nxt = S_VAL_CH; end
          CLS_NL:    begin s.reject = 1'b0; s.nxt = S_COMMIT; end
          default:   s.reject = 1'b1;
        endcase
      end
      S_VAL_BLNK: begin
        case (cls)
          CLS_BLANK: begin s.reject = 1'b0; s.nxt = S_VAL_BLNK; end
          CLS_NL:    begin s.reject = 1'b0; s.nxt = S_COMMIT; end
          default:   s.reject = 1'b1;
        endcase
      end
      default: s.reject = 1'b1;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/ilt_fifo.sv]
// Small register-based FIFO used for the token queue and the result queue.
// Depends on nothing; DEPTH must be a power of two, at least two.
`timescale 1ns / 1ps

module ilt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + CntW'(1);
    else if (do_pop && !do_push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/ilt_front.sv]
// Front end of the tokenizer: takes raw bytes and classifies them into tokens.
// Depends on ilt_pkg.
`timescale 1ns / 1ps

module ilt_front
  import ilt_pkg::*;
(
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_in_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output tok_t       q_item_o
);

  assign full     = q_full_i;
  assign q_push_o = push;

  always_comb begin
    q_item_o.ch      = byte_in_i;
    q_item_o.cls     = classify(byte_in_i);
    q_item_o.is_nl   = (byte_in_i == CharNl);
    q_item_o.is_hash = (byte_in_i == CharHash);
  end

endmodule

[rtl/core/ilt_back.sv]
// Back end of the tokenizer: line and column counters, comment tracking,
// the line grammar and event generation. Depends on ilt_pkg.
`timescale 1ns / 1ps

module ilt_back
  import ilt_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tok_valid_i,
  input  tok_t tok_i,
  output logic tok_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  logic [COUNTER_BITS-1:0] line_q, line_d;
  logic [COUNTER_BITS-1:0] col_q, col_d;
  dfa_state_e              state_q, state_d;
  logic                    comment_q, comment_d;
  logic                    halted_q, halted_d;
  logic                    fire;
  dfa_step_t               step;
  ev_e                     ev;
  logic [7:0]              ch;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(logic [COUNTER_BITS-1:0] v);
    return (v == '1) ? v : v + COUNTER_BITS'(1);
  endfunction

  function automatic logic [15:0] clip16(logic [COUNTER_BITS-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    return (|ext[31:16]) ? 16'hFFFF : ext[15:0];
  endfunction

  assign fire       = tok_valid_i && !res_full_i;
  assign tok_pop_o  = fire;
  assign res_push_o = fire;
  assign step       = dfa_next(state_q, tok_i.cls);

  always_comb begin
    line_d    = line_q;
    col_d     = col_q;
    state_d   = state_q;
    comment_d = comment_q;
    halted_d  = halted_q;
    ev        = EV_NONE;
    ch        = 8'h00;
    if (halted_q) begin
      ev = EV_HALTED;
    end else begin
      if (tok_i.is_nl) begin
        line_d    = sat_inc(line_q);
        col_d     = '0;
        comment_d = 1'b0;
      end else begin
        col_d = sat_inc(col_q);
      end
      // A newline ends a comment and is then parsed like any other newline.
      if (comment_q && !tok_i.is_nl) begin
        ev = EV_NONE;
      end else if (tok_i.is_hash) begin
        comment_d = 1'b1;
      end else if (tok_i.cls == CLS_BAD || step.reject) begin
        ev       = EV_ERROR;
        ch       = tok_i.ch;
        halted_d = 1'b1;
      end else begin
        state_d = step.nxt;
        case (step.nxt)
          S_SECT_CH: begin ev = EV_SECT_CH; ch = tok_i.ch; end
          S_KEY_CH:  begin ev = EV_KEY_CH;  ch = tok_i.ch; end
          S_VAL_CH:  begin ev = EV_VAL_CH;  ch = tok_i.ch; end
          S_COMMIT: begin
            if (state_q == S_LINE_END) ev = EV_SECT_END;
            else if (state_q inside {S_VAL_CH, S_VAL_BLNK}) ev = EV_PAIR_END;
          end
          default: ev = EV_NONE;
        endcase
      end
    end
  end

  always_comb begin
    res_o.ev   = ev;
    res_o.ch   = ch;
    res_o.line = clip16(line_d);
    res_o.col  = clip16(col_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q    <= COUNTER_BITS'(1);
      col_q     <= '0;
      state_q   <= S_IDLE;
      comment_q <= 1'b0;
      halted_q  <= 1'b0;
    end else if (fire) begin
      line_q    <= line_d;
      col_q     <= col_d;
      state_q   <= state_d;
      comment_q <= comment_d;
      halted_q  <= halted_d;
    end
  end

endmodule

[rtl/core/ini_line_tokenizer.sv]
// INI line tokenizer, top level: classifying front end, token queue, parser back end
// and result queue. One result per byte; a pushed byte is registered in the token queue,
// parsed combinationally by the back end and its result registered in the result queue,
// so one byte per cycle is sustained while results are popped.
// Reset (asynchronous, active low) empties both queues and returns the parser to
// its idle state, line 1, column 0, out of any comment or halt.
`timescale 1ns / 1ps

module ini_line_tokenizer
  import ilt_pkg::*;
#(
  parameter int COUNTER_BITS = 16,
  parameter int QUEUE_DEPTH  = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_res_o,
  output logic [7:0]  char_out_o,
  output logic [15:0] line_no_o,
  output logic [15:0] col_no_o
);

  logic tok_push, tok_full, tok_empty, tok_pop;
  tok_t tok_wdata, tok_rdata;
  logic res_push, res_full;
  res_t res_wdata, res_rdata;
  logic [$bits(tok_t)-1:0] tok_rbits;
  logic [$bits(res_t)-1:0] res_rbits;

  ilt_front u_front (
    .push      (push),
    .full      (full),
    .byte_in_i (byte_in_i),
    .q_full_i  (tok_full),
    .q_push_o  (tok_push),
    .q_item_o  (tok_wdata)
  );

  ilt_fifo #(
    .WIDTH ($bits(tok_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .wdata_i (tok_wdata),
    .full_o  (tok_full),
    .pop_i   (tok_pop),
    .rdata_o (tok_rbits),
    .empty_o (tok_empty)
  );

  assign tok_rdata = tok_t'(tok_rbits);

  ilt_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!tok_empty),
    .tok_i       (tok_rdata),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wdata)
  );

  ilt_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rbits),
    .empty_o (empty)
  );

  assign res_rdata   = res_t'(res_rbits);
  assign event_res_o = res_rdata.ev;
  assign char_out_o  = res_rdata.ch;
  assign line_no_o   = res_rdata.line;
  assign col_no_o    = res_rdata.col;

  // Every token taken from the queue produces exactly one result transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_pop || res_push) |-> (tok_pop && res_push))
    else $error("token pop and result push out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (line_no_o != 16'd0))
    else $error("line number of zero reported");

endmodule

[dv/testbench.sv]
// Self-checking testbench for ini_line_tokenizer: well-formed INI text with random content,
// comment noise and one closing syntax error, checked byte by byte.
// Depends on ilt_pkg and the ini_line_tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
  import ilt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  typedef struct {
    ev_e         ev;
    logic [7:0]  ch;
    logic [15:0] line;
    logic [15:0] col;
  } tok_event_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  byte_in_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  event_res_o;
  logic [7:0]  char_out_o;
  logic [15:0] line_no_o;
  logic [15:0] col_no_o;

  ini_line_tokenizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .byte_in_i   (byte_in_i),
    .empty       (empty),
    .pop         (pop),
    .event_res_o (event_res_o),
    .char_out_o  (char_out_o),
    .line_no_o   (line_no_o),
    .col_no_o    (col_no_o)
  );

  // Tokenizer state as it stands after every accepted byte.
  dfa_state_e  tok_state = S_IDLE;
  bit          tok_in_comment = 1'b0;
  bit          tok_halted = 1'b0;
  logic [15:0] tok_line = 16'd1;
  logic [15:0] tok_col = 16'd0;

  tok_event_t  pending_events[$];
  logic [7:0]  text_q[$];
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          fails = 0;
  int          bytes_sent = 0;
  int          cycles = 0;
  int          ev_seen[8];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic cls_e byte_class(input logic [7:0] b);
    if (b == CH_SPACE || b == CH_TAB) return CLS_BLANK;
    if (b == CharNl) return CLS_NL;
    if (b == CH_EQ) return CLS_EQ;
    if (b == CH_OPEN) return CLS_OPEN;
    if (b == CH_CLOSE) return CLS_CLOSE;
    if ((b > 8'h20 && b < 8'h7F) || b > 8'h7F) return CLS_STR;
    return CLS_BAD;
  endfunction

  // Line grammar; ok is cleared for any class the current state does not take.
  function automatic dfa_state_e grammar_step(input dfa_state_e cur, input cls_e k,
                                              output bit ok);
    dfa_state_e nxt;
    nxt = cur;
    ok = 1'b1;
    case (cur)
      S_IDLE:
        case (k)
          CLS_BLANK, CLS_NL: nxt = S_IDLE;
          CLS_OPEN:          nxt = S_SECT_OPEN;
          default:           ok = 1'b0;
        endcase
      S_SECT_OPEN:
        case (k)
          CLS_BLANK: nxt = S_SECT_OPEN;
          CLS_STR:   nxt = S_SECT_CH;
          default:   ok = 1'b0;
        endcase
      S_SECT_CH:
        case (k)
          CLS_BLANK: nxt = S_SECT_BLNK;
          CLS_STR:   nxt = S_SECT_CH;
          CLS_CLOSE: nxt = S_LINE_END;
          default:   ok = 1'b0;
        endcase
      S_SECT_BLNK:
        case (k)
          CLS_BLANK: nxt = S_SECT_BLNK;
          CLS_CLOSE: nxt = S_LINE_END;
          default:   ok = 1'b0;
        endcase
      S_LINE_END:
        case (k)
          CLS_BLANK: nxt = S_LINE_END;
          CLS_NL:    nxt = S_COMMIT;
          default:   ok = 1'b0;
        endcase
      S_COMMIT:
        case (k)
          CLS_BLANK, CLS_NL: nxt = S_COMMIT;
          CLS_STR:           nxt = S_KEY_CH;
          CLS_OPEN:          nxt = S_SECT_OPEN;
          default:           ok = 1'b0;
        endcase
      S_KEY_CH:
        case (k)
          CLS_BLANK: nxt = S_KEY_BLNK;
          CLS_STR:   nxt = S_KEY_CH;
          CLS_EQ:    nxt = S_EQ_BLNK;
          default:   ok = 1'b0;
        endcase
      S_KEY_BLNK:
        case (k)
          CLS_BLANK: nxt = S_KEY_BLNK;
          CLS_EQ:    nxt = S_EQ_BLNK;
          default:   ok = 1'b0;
        endcase
      S_EQ_BLNK:
        case (k)
          CLS_BLANK: nxt = S_EQ_BLNK;
          CLS_STR:   nxt = S_VAL_CH;
          default:   ok = 1'b0;
        endcase
      S_VAL_CH:
        case (k)
          CLS_BLANK: nxt = S_VAL_BLNK;
          CLS_STR:   nxt = S_VAL_CH;
          CLS_NL:    nxt = S_COMMIT;
          default:   ok = 1'b0;
        endcase
      S_VAL_BLNK:
        case (k)
          CLS_BLANK: nxt = S_VAL_BLNK;
          CLS_NL:    nxt = S_COMMIT;
          default:   ok = 1'b0;
        endcase
      default: ok = 1'b0;
    endcase
    return nxt;
  endfunction

  function automatic void predict_token(input logic [7:0] b);
    tok_event_t e;
    dfa_state_e nxt;
    bit         ok;
    e.ev = EV_NONE;
    e.ch = 8'h00;
    if (tok_halted) begin
      e.ev = EV_HALTED;
    end else begin
      if (b == CharNl) begin
        if (tok_line != 16'hFFFF) tok_line++;
        tok_col = 16'h0000;
        tok_in_comment = 1'b0;
      end else if (tok_col != 16'hFFFF) begin
        tok_col++;
      end
      // Comment bytes, the opening hash included, never reach the grammar.
      if (!tok_in_comment) begin
        if (b == CharHash) begin
          tok_in_comment = 1'b1;
        end else begin
          nxt = grammar_step(tok_state, byte_class(b), ok);
          if (!ok) begin
            e.ev = EV_ERROR;
            e.ch = b;
            tok_halted = 1'b1;
          end else begin
            case (nxt)
              S_SECT_CH: e.ev = EV_SECT_CH;
              S_KEY_CH:  e.ev = EV_KEY_CH;
              S_VAL_CH:  e.ev = EV_VAL_CH;
              S_COMMIT: begin
                if (tok_state == S_LINE_END) e.ev = EV_SECT_END;
                else if (tok_state == S_VAL_CH || tok_state == S_VAL_BLNK) e.ev = EV_PAIR_END;
              end
              default: ;
            endcase
            if (e.ev == EV_SECT_CH || e.ev == EV_KEY_CH || e.ev == EV_VAL_CH) e.ch = b;
            tok_state = nxt;
          end
        end
      end
    end
    e.line = tok_line;
    e.col = tok_col;
    pending_events.insert(pending_events.size(), e);
  endfunction

  function automatic void compare_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fails++;
    end
  endfunction

  function automatic void check_result();
    tok_event_t want;
    if (pending_events.size() == 0) begin
      $display("%0t: result with no transaction pending: event %0d char %0h line %0d col %0d",
               $time, event_res_o, char_out_o, line_no_o, col_no_o);
      fails++;
      return;
    end
    want = pending_events.pop_front();
    ev_seen[want.ev]++;
    compare_field("event_res", 16'(want.ev), 16'(event_res_o));
    compare_field("char_out", 16'(want.ch), 16'(char_out_o));
    compare_field("line_no", want.line, line_no_o);
    compare_field("col_no", want.col, col_no_o);
  endfunction

  // Result side: check every popped transaction, stall pop in short random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result();
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
      pop <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               pending_events.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    byte_in_i <= b;
    do @(posedge clk_i); while (full);
    predict_token(b);
    bytes_sent++;
  endtask

  task automatic send_text();
    while (text_q.size() != 0) send_byte(text_q.pop_front());
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
  endtask

  function automatic void add_text(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) add_text(s[i]);
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= CharNl) b++;
    return b;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      b = 8'($urandom_range(8'h80, 8'hFF));
      return b;
    end
    do b = 8'($urandom_range(8'h21, 8'h7E));
    while (b == CharHash || b == CH_EQ || b == CH_OPEN || b == CH_CLOSE);
    return b;
  endfunction

  function automatic void put_blanks(input int most);
    repeat ($urandom_range(0, most))
      add_text(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void put_name(input int most);
    repeat ($urandom_range(1, most)) add_text(name_char());
  endfunction

  // A comment may carry any byte but a newline, illegal ones too.
  function automatic void put_line_end(input int comment_odds);
    if ($urandom_range(0, 9) < comment_odds) begin
      add_text(CharHash);
      repeat ($urandom_range(0, 16)) add_text(noise_byte());
    end
    add_text(CharNl);
  endfunction

  function automatic void put_section_line();
    put_blanks(2);
    add_text(CH_OPEN);
    put_blanks(2);
    put_name(6);
    put_blanks(2);
    add_text(CH_CLOSE);
    put_blanks(2);
    put_line_end(3);
  endfunction

  function automatic void put_pair_line();
    put_blanks(2);
    put_name(6);
    put_blanks(2);
    add_text(CH_EQ);
    put_blanks(2);
    put_name(8);
    put_blanks(2);
    put_line_end(3);
  endfunction

  function automatic void put_blank_line();
    put_blanks(3);
    put_line_end(7);
  endfunction

  // Leading blanks, section with byte FF, comment with illegal bytes, pairs with and
  // without blanks, value ended by a comment.
  task automatic test_directed_lines();
    put_str("\t[ ");
    add_text(8'hFF);
    put_str("]\t#");
    add_text(8'h00);
    add_text(8'h7F);
    add_text(8'hFF);
    add_text(CharNl);
    put_str("k!=~\n");
    put_str(" a =\tb #");
    add_text(8'h80);
    add_text(CharNl);
    send_text();
  endtask

  task automatic test_random_text(input int n_bytes, input bit allow_idle);
    int  stop_at;
    bit  drained;
    int  pick;
    stop_at = bytes_sent + n_bytes;
    drained = 1'b0;
    idle_on = allow_idle;
    while (bytes_sent < stop_at) begin
      if (allow_idle && $urandom_range(0, 19) == 0) idle_on = !idle_on;
      if (!drained && bytes_sent >= stop_at - n_bytes / 2) begin
        wait_for_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 19);
      // Key/value lines are only legal once a section header has been committed.
      if (tok_state == S_IDLE) begin
        if (pick < 6) put_blank_line();
        else put_section_line();
      end else begin
        if (pick < 3) put_section_line();
        else if (pick < 15) put_pair_line();
        else put_blank_line();
      end
      send_text();
    end
  endtask

  // Only one syntax error fits in a run, so the kind is picked at random.
  task automatic test_error_halt();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 6);
    case (pick)
      0: begin
        b = 8'($urandom_range(0, 30));
        if (b == 8'd30) b = 8'h7F;
        else if (b >= 8'd9) b = b + 8'd2;
        add_text(b);
      end
      1: add_text(CH_CLOSE);
      2: put_str("[\n");
      3: put_str("[ab=");
      4: put_str("[a]x");
      5: add_text(CH_EQ);
      default: put_str("[s]\nk =\n");
    endcase
    send_text();
    for (int i = 0; i < 8; i++) send_byte((i == 3) ? CharNl : 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_lines();
    test_random_text(1500, 1'b1);
    test_random_text(400, 1'b0);
    test_error_halt();
    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d bytes: %0d section, %0d key, %0d value chars, %0d sections, %0d pairs.",
             bytes_sent, ev_seen[EV_SECT_CH], ev_seen[EV_KEY_CH], ev_seen[EV_VAL_CH],
             ev_seen[EV_SECT_END], ev_seen[EV_PAIR_END]);
    $display("Closing error path: %0d syntax error and %0d halted bytes after it.",
             ev_seen[EV_ERROR], ev_seen[EV_HALTED]);
    if (fails == 0 && pending_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
